[rtl/hsrc_pkg.sv]
`timescale 1ns / 1ps
// Shared types and constants for the heading smoother and rudder control block.
// Used by hsrc_ctrl, hsrc_dp and heading_smoother_rudder_control_top.
package hsrc_pkg;

    // Heading scale: 1/128 degree per code
    localparam logic [15:0] FULL_TURN_FINE = 16'd46080;
    localparam logic [15:0] HALF_TURN_FINE = 16'd23040;
    localparam logic [8:0]  FULL_TURN_DEG  = 9'd360;
    localparam logic [8:0]  HALF_TURN_DEG  = 9'd180;
    localparam logic [7:0]  RUDDER_CENTER  = 8'd90;
    localparam logic [7:0]  RUDDER_MAX     = 8'd180;

    // Configuration register indexes and reset values
    localparam logic [1:0]  CFG_SMOOTHING_WEIGHT = 2'd0;
    localparam logic [1:0]  CFG_STEER_GAIN       = 2'd1;
    localparam logic [1:0]  CFG_DEADZONE_DEG     = 2'd2;
    localparam logic [15:0] WEIGHT_RESET         = 16'd6554;
    localparam logic [11:0] GAIN_RESET           = 12'd256;
    localparam logic [7:0]  DEADZONE_RESET       = 8'd5;

    // Controller to datapath commands, one step per cycle, finish may stall
    typedef struct packed {
        logic load;        // capture request fields
        logic mul_smooth;  // product = wrapped difference * weight
        logic update;      // new smoothed heading
        logic mul_gain;    // product = heading error * gain, deadzone test
        logic finish;      // rudder angle into output register
    } dp_cmd_t;

endpackage

[rtl/hsrc_ctrl.sv]
`timescale 1ns / 1ps
// Sequencer for the heading smoother: steps one request through the datapath.
// Depends on hsrc_pkg (dp_cmd_t).
module hsrc_ctrl
    import hsrc_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    s_tvalid,
    output logic    s_tready,
    output logic    m_tvalid,
    input  logic    m_tready,
    output dp_cmd_t cmd
);

    typedef enum logic [4:0] {
        ST_IDLE   = 5'b00001,
        ST_SMOOTH = 5'b00010,
        ST_UPDATE = 5'b00100,
        ST_GAIN   = 5'b01000,
        ST_FINISH = 5'b10000
    } state_t;

    state_t state_reg, state_next;
    logic   valid_reg, valid_next;

    // Next state and commands
    always_comb
    begin
        state_next = state_reg;
        valid_next = valid_reg;
        cmd        = '0;
        if (valid_reg && m_tready)
        begin
            valid_next = 1'b0;
        end
        case (state_reg)
            ST_IDLE:
            begin
                if (s_tvalid)
                begin
                    cmd.load   = 1'b1;
                    state_next = ST_SMOOTH;
                end
            end
            ST_SMOOTH:
            begin
                cmd.mul_smooth = 1'b1;
                state_next     = ST_UPDATE;
            end
            ST_UPDATE:
            begin
                cmd.update = 1'b1;
                state_next = ST_GAIN;
            end
            ST_GAIN:
            begin
                cmd.mul_gain = 1'b1;
                state_next   = ST_FINISH;
            end
            ST_FINISH:
            begin
                // output register free or being emptied this cycle
                if (!valid_reg || m_tready)
                begin
                    cmd.finish = 1'b1;
                    valid_next = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            valid_reg <= valid_next;
        end
    end

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = valid_reg;

endmodule

[rtl/hsrc_dp.sv]
`timescale 1ns / 1ps
// Datapath: configuration registers, smoothed heading state, one shared
// 18x18 signed multiplier and the output register. Depends on hsrc_pkg.
module hsrc_dp
    import hsrc_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [1:0]  cfg_addr,
    input  logic [15:0] cfg_data,
    input  logic [15:0] in_heading,
    input  logic [8:0]  in_target,
    input  dp_cmd_t     cmd,
    output logic [7:0]  out_angle,
    output logic        out_write,
    output logic [15:0] out_heading
);

    logic [15:0] weight_reg;
    logic [11:0] gain_reg;
    logic [7:0]  deadzone_reg;
    logic [15:0] smooth_reg, smooth_next;
    logic        primed_reg;
    logic [15:0] sample_reg;
    logic [8:0]  target_reg;
    logic signed [35:0] prod_reg;
    logic        write_reg;
    logic [7:0]  angle_reg;
    logic        owrite_reg;
    logic [15:0] oheading_reg;

    logic signed [17:0] dif_raw, dif;
    logic signed [17:0] mul_a, mul_b;
    logic signed [35:0] mul_p;
    logic signed [17:0] sum_raw;
    logic signed [9:0]  err_raw, err;
    logic [8:0]         err_mag;
    logic               in_dead;
    logic signed [21:0] prod_adj;
    logic signed [13:0] quot;
    logic signed [14:0] angle_raw;
    logic [7:0]         angle_clamped;

    // Configuration writes, out-of-list indexes ignored
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            weight_reg   <= WEIGHT_RESET;
            gain_reg     <= GAIN_RESET;
            deadzone_reg <= DEADZONE_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_addr)
                CFG_SMOOTHING_WEIGHT: weight_reg   <= cfg_data;
                CFG_STEER_GAIN:       gain_reg     <= cfg_data[11:0];
                CFG_DEADZONE_DEG:     deadzone_reg <= cfg_data[7:0];
                default:              ;
            endcase
        end
    end

    // Shortest-arc difference, wrapped to +-half turn
    always_comb
    begin
        dif_raw = $signed({2'b00, sample_reg}) - $signed({2'b00, smooth_reg});
        dif     = dif_raw;
        if (dif_raw > $signed({2'b00, HALF_TURN_FINE}))
        begin
            dif = dif_raw - $signed({2'b00, FULL_TURN_FINE});
        end
        else if (dif_raw < -$signed({2'b00, HALF_TURN_FINE}))
        begin
            dif = dif_raw + $signed({2'b00, FULL_TURN_FINE});
        end
    end

    // Heading error toward target, wrapped to +-180, and deadzone test
    always_comb
    begin
        err_raw = $signed({1'b0, target_reg}) - $signed({1'b0, smooth_reg[15:7]});
        err     = err_raw;
        if (err_raw > $signed({1'b0, HALF_TURN_DEG}))
        begin
            err = err_raw - $signed({1'b0, FULL_TURN_DEG});
        end
        else if (err_raw < -$signed({1'b0, HALF_TURN_DEG}))
        begin
            err = err_raw + $signed({1'b0, FULL_TURN_DEG});
        end
        err_mag = err[9] ? 9'(-err) : err[8:0];
        in_dead = (err_mag < {1'b0, deadzone_reg});
    end

    // Shared multiplier operand select
    always_comb
    begin
        if (cmd.mul_gain)
        begin
            mul_a = 18'(err);
            mul_b = $signed({6'd0, gain_reg});
        end
        else
        begin
            mul_a = dif;
            mul_b = $signed({2'b00, weight_reg});
        end
        mul_p = mul_a * mul_b;
    end

    // Smoothed sum: floor of product / 65536 added, wrapped into one turn
    always_comb
    begin
        sum_raw     = $signed({2'b00, smooth_reg}) + prod_reg[33:16];
        smooth_next = sum_raw[15:0];
        if (sum_raw < 0)
        begin
            smooth_next = 16'(sum_raw + $signed({2'b00, FULL_TURN_FINE}));
        end
        else if (sum_raw >= $signed({2'b00, FULL_TURN_FINE}))
        begin
            smooth_next = 16'(sum_raw - $signed({2'b00, FULL_TURN_FINE}));
        end
    end

    // Rudder angle: product / 256 toward zero, centred, clamped
    always_comb
    begin
        prod_adj  = prod_reg[21:0] + (prod_reg[35] ? 22'sd255 : 22'sd0);
        quot      = 14'(prod_adj >>> 8);
        angle_raw = 15'(quot) + $signed({7'd0, RUDDER_CENTER});
        if (angle_raw > $signed({7'd0, RUDDER_MAX}))
        begin
            angle_clamped = RUDDER_MAX;
        end
        else if (angle_raw < 0)
        begin
            angle_clamped = 8'd0;
        end
        else
        begin
            angle_clamped = angle_raw[7:0];
        end
    end

    // Smoothing state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            smooth_reg <= '0;
            primed_reg <= 1'b0;
        end
        else if (cmd.update)
        begin
            primed_reg <= 1'b1;
            smooth_reg <= primed_reg ? smooth_next : sample_reg;
        end
    end

    // Request capture with range reduction, product and output registers
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            sample_reg <= (in_heading >= FULL_TURN_FINE) ? in_heading - FULL_TURN_FINE
                                                         : in_heading;
            target_reg <= (in_target >= FULL_TURN_DEG) ? in_target - FULL_TURN_DEG
                                                       : in_target;
        end
        if (cmd.mul_smooth || cmd.mul_gain)
        begin
            prod_reg <= mul_p;
        end
        if (cmd.mul_gain)
        begin
            write_reg <= !in_dead;
        end
        if (cmd.finish)
        begin
            angle_reg    <= write_reg ? angle_clamped : 8'd0;
            owrite_reg   <= write_reg;
            oheading_reg <= smooth_reg;
        end
    end

    assign out_angle   = angle_reg;
    assign out_write   = owrite_reg;
    assign out_heading = oheading_reg;

endmodule

[rtl/heading_smoother_rudder_control_top.sv]
`timescale 1ns / 1ps
// Top level of the heading smoother and proportional rudder control.
// Depends on hsrc_pkg, hsrc_ctrl and hsrc_dp.
//
// Each request carries a compass heading (1/128 degree) and a target heading
// (whole degrees) and yields one result: the smoothed heading, a rudder angle
// (0..180, 90 centred) and a write flag that is low inside the deadzone, where
// the angle reads 0. The first request after reset loads the smoothed heading
// directly. The request is captured at acceptance and then steps through the
// smoothing multiply, heading update, gain multiply and angle states; the single
// 18x18 multiplier is shared by the smoothing and gain steps, and a new request is
// taken only once the last one has been written to the output register.
// The result sits in an output register, and the next
// request is accepted while it waits. Configuration writes take effect at once
// and are meant to be made while no request is in flight.
module heading_smoother_rudder_control_top
    import hsrc_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    // configuration write port
    input  logic        cfg_we,
    input  logic [1:0]  cfg_addr,
    input  logic [15:0] cfg_data,
    // request stream
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,   // [15:0] measured_heading, [24:16] target_heading
    // result stream
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata,   // [7:0] rudder_angle, [23:8] filtered_heading
    output logic        m_tuser    // [0] rudder_write
);

    dp_cmd_t     cmd;
    logic [7:0]  rudder_angle;
    logic        rudder_write;
    logic [15:0] filtered_heading;

    hsrc_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .cmd      (cmd)
    );

    hsrc_dp u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_we      (cfg_we),
        .cfg_addr    (cfg_addr),
        .cfg_data    (cfg_data),
        .in_heading  (s_tdata[15:0]),
        .in_target   (s_tdata[24:16]),
        .cmd         (cmd),
        .out_angle   (rudder_angle),
        .out_write   (rudder_write),
        .out_heading (filtered_heading)
    );

    // Result packing
    assign m_tdata = {filtered_heading, rudder_angle};
    assign m_tuser = rudder_write;

endmodule

[tb/heading_smoother_rudder_control_top_test.sv]
`timescale 1ns / 1ps
// Self-checking testbench for heading_smoother_rudder_control_top: directed and random requests.
// It predicts each result from its own mirror of the smoother and rudder law.
// Depends on hsrc_pkg and the top level only.
module heading_smoother_rudder_control_top_test;
    import hsrc_pkg::*;

    localparam int FINE_TURN   = int'(FULL_TURN_FINE);
    localparam int FINE_HALF   = int'(HALF_TURN_FINE);
    localparam int DEG_TURN    = int'(FULL_TURN_DEG);
    localparam int DEG_HALF    = int'(HALF_TURN_DEG);
    localparam int CENTRE_DEG  = int'(RUDDER_CENTER);
    localparam int RUDDER_TOP  = int'(RUDDER_MAX);
    localparam logic [1:0] CFG_UNUSED_INDEX = 2'd3;
    localparam int IDLE_LIMIT  = 5000;   // cycles with no handshake before giving up
    localparam int SETTLE      = 10;

    typedef struct packed {
        logic [7:0]  angle;
        logic        write_en;
        logic [15:0] heading;
    } steer_result_t;

    logic        clk;
    logic        rst_n;
    logic        cfg_we;
    logic [1:0]  cfg_addr;
    logic [15:0] cfg_data;
    logic        s_tvalid;
    logic        s_tready;
    logic [31:0] s_tdata;   // [15:0] measured_heading, [24:16] target_heading
    logic        m_tvalid;
    logic        m_tready;
    logic [23:0] m_tdata;   // [7:0] rudder_angle, [23:8] filtered_heading
    logic        m_tuser;   // [0] rudder_write

    // predictor state and register mirror
    logic [15:0] smoothed_hdg;
    bit          heading_primed;
    logic [15:0] weight_cfg;
    logic [11:0] gain_cfg;
    logic [7:0]  deadzone_cfg;

    steer_result_t pending_steer[$];
    int          mismatches;
    int          idle_cycles;
    bit          steady_flow;   // no idling on either side while set

    heading_smoother_rudder_control_top dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg_we   (cfg_we),
        .cfg_addr (cfg_addr),
        .cfg_data (cfg_data),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    always #5 clk = ~clk;

    // gap lengths: mostly none or short, now and then long
    function automatic int pick_gap();
        int roll;
        if (steady_flow)
            return 0;
        roll = $urandom_range(0, 99);
        if (roll < 55)
            return 0;
        if (roll < 90)
            return $urandom_range(1, 3);
        return $urandom_range(5, 30);
    endfunction

    // shortest-arc smoother followed by the proportional rudder law
    function automatic steer_result_t predict_steering(input logic [15:0] meas,
                                                       input logic [8:0] tgt);
        steer_result_t r;
        int sample;
        int target;
        int dif;
        int hdg;
        int err;
        int mag;
        int angle;
        longint prod;
        sample = int'(meas);
        if (sample >= FINE_TURN)
            sample -= FINE_TURN;
        target = int'(tgt);
        if (target >= DEG_TURN)
            target -= DEG_TURN;
        if (!heading_primed)
        begin
            hdg = sample;
            heading_primed = 1'b1;
        end
        else
        begin
            hdg = int'(smoothed_hdg);
            dif = sample - hdg;
            if (dif > FINE_HALF)
                dif -= FINE_TURN;
            if (dif < -FINE_HALF)
                dif += FINE_TURN;
            // arithmetic shift floors toward minus infinity
            prod = longint'(dif) * longint'(weight_cfg);
            hdg += int'(prod >>> 16);
            if (hdg < 0)
                hdg += FINE_TURN;
            if (hdg >= FINE_TURN)
                hdg -= FINE_TURN;
        end
        smoothed_hdg = 16'(hdg);
        err = target - (hdg >>> 7);
        if (err > DEG_HALF)
            err -= DEG_TURN;
        if (err < -DEG_HALF)
            err += DEG_TURN;
        mag = (err < 0) ? -err : err;
        r.angle    = '0;
        r.write_en = 1'b0;
        r.heading  = 16'(hdg);
        if (mag >= int'(deadzone_cfg))
        begin
            // integer division truncates toward zero
            angle = CENTRE_DEG + (err * int'(gain_cfg)) / 256;
            if (angle > RUDDER_TOP)
                angle = RUDDER_TOP;
            if (angle < 0)
                angle = 0;
            r.angle    = 8'(angle);
            r.write_en = 1'b1;
        end
        return r;
    endfunction

    // one request, after a random gap; expectation queued on acceptance
    task automatic send_heading(input logic [15:0] meas, input logic [8:0] tgt);
        int gap;
        gap = pick_gap();
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {7'b0, tgt, meas};
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        pending_steer.push_back(predict_steering(meas, tgt));
    endtask

    // register write once every result has drained
    task automatic write_reg(input logic [1:0] addr, input logic [15:0] data);
        s_tvalid <= 1'b0;
        while (pending_steer.size() != 0)
            @(posedge clk);
        repeat (SETTLE) @(posedge clk);
        cfg_we   <= 1'b1;
        cfg_addr <= addr;
        cfg_data <= data;
        @(posedge clk);
        cfg_we   <= 1'b0;
        case (addr)
            CFG_SMOOTHING_WEIGHT: weight_cfg   = data;
            CFG_STEER_GAIN:       gain_cfg     = data[11:0];
            CFG_DEADZONE_DEG:     deadzone_cfg = data[7:0];
            default: ;
        endcase
    endtask

    task automatic set_controls(input logic [15:0] weight, input logic [15:0] gain,
                                input logic [15:0] deadzone);
        write_reg(CFG_SMOOTHING_WEIGHT, weight);
        write_reg(CFG_STEER_GAIN, gain);
        write_reg(CFG_DEADZONE_DEG, deadzone);
    endtask

    // first request after reset loads the heading, reset registers in force
    task automatic test_first_sample();
        send_heading(16'd12800, 9'd100);
        send_heading(16'd12900, 9'd110);
    endtask

    // crossing north, field extremes and out-of-range headings and targets
    task automatic test_wrap_and_range();
        send_heading(16'd46079, 9'd0);
        send_heading(16'd0, 9'd359);
        send_heading(16'd46080, 9'd360);
        send_heading(16'hFFFF, 9'h1FF);
        send_heading(16'd100, 9'd180);
    endtask

    // full weight and gain drive the rudder to both stops; zero gain and deadzone
    task automatic test_rudder_limits();
        set_controls(16'hFFFF, 16'd4095, 16'd0);
        send_heading(16'd0, 9'd180);
        send_heading(16'd23040, 9'd0);
        send_heading(16'd23040, 9'd90);
        send_heading(16'd23040, 9'd270);
        set_controls(16'd1, 16'hF000, 16'd0);   // upper gain bits are dropped
        send_heading(16'd11520, 9'd10);
        send_heading(16'd11520, 9'd180);
    endtask

    // zero weight: heading holds its smoothed value whatever is measured
    task automatic test_zero_weight();
        set_controls(16'd0, 16'd256, 16'd5);
        send_heading(16'd0, 9'd45);
        send_heading(16'd40000, 9'd300);
        send_heading(16'd65000, 9'd2);
    endtask

    // deadzone at the half turn and beyond; unused register index
    task automatic test_deadzone_limits();
        set_controls(16'd6554, 16'd512, 16'd180);
        send_heading(16'd0, 9'd180);
        write_reg(CFG_DEADZONE_DEG, 16'd255);
        send_heading(16'd0, 9'd180);
        write_reg(CFG_UNUSED_INDEX, 16'hFFFF);
        send_heading(16'd0, 9'd90);
    endtask

    // random phases of requests, each phase under its own register setting
    task automatic test_random_tracking();
        int phase;
        int n;
        int pick;
        logic [15:0] meas;
        logic [8:0]  tgt;
        logic [15:0] w;
        logic [15:0] g;
        logic [15:0] d;
        for (phase = 0; phase < 10; phase++)
        begin
            pick = $urandom_range(0, 5);
            w = (pick == 0) ? 16'd1 : (pick == 1) ? 16'hFFFF : (pick == 2) ? 16'd0 :
                16'($urandom_range(1, 65535));
            pick = $urandom_range(0, 4);
            g = (pick == 0) ? 16'd0 : (pick == 1) ? 16'd4095 : 16'($urandom_range(0, 4095));
            pick = $urandom_range(0, 5);
            d = (pick == 0) ? 16'd0 : (pick == 1) ? 16'd180 : (pick == 2) ? 16'd255 :
                16'($urandom_range(0, 20));
            set_controls(w, g, d);
            if ($urandom_range(0, 3) == 0)
                write_reg(CFG_UNUSED_INDEX, 16'($urandom));
            steady_flow = (phase % 3 == 0);
            for (n = 0; n < 40; n++)
            begin
                pick = $urandom_range(0, 99);
                if (pick < 10)
                    meas = 16'($urandom_range(46080, 65535));
                else if (pick < 40)
                    meas = 16'((int'(smoothed_hdg) + $urandom_range(0, 4000) - 2000
                                + FINE_TURN) % FINE_TURN);
                else
                    meas = 16'($urandom_range(0, 46079));
                pick = $urandom_range(0, 99);
                if (pick < 10)
                    tgt = 9'($urandom_range(360, 511));
                else if (pick < 50)
                    // near the current heading, around the deadzone edge
                    tgt = 9'((int'(smoothed_hdg >> 7) + $urandom_range(0, 24) - 12
                              + DEG_TURN) % DEG_TURN);
                else
                    tgt = 9'($urandom_range(0, 359));
                send_heading(meas, tgt);
            end
        end
        steady_flow = 1'b0;
    endtask

    // result checker
    always @(posedge clk)
    begin
        steer_result_t exp_r;
        if (rst_n && m_tvalid && m_tready)
        begin
            if (pending_steer.size() == 0)
            begin
                $display("%0t: unexpected result angle=%0d write=%0b heading=%0d",
                         $time, m_tdata[7:0], m_tuser, m_tdata[23:8]);
                mismatches++;
            end
            else
            begin
                exp_r = pending_steer.pop_front();
                if (m_tdata[7:0] !== exp_r.angle)
                begin
                    $display("%0t: rudder_angle expected %0d actual %0d",
                             $time, exp_r.angle, m_tdata[7:0]);
                    mismatches++;
                end
                if (m_tuser !== exp_r.write_en)
                begin
                    $display("%0t: rudder_write expected %0b actual %0b",
                             $time, exp_r.write_en, m_tuser);
                    mismatches++;
                end
                if (m_tdata[23:8] !== exp_r.heading)
                begin
                    $display("%0t: filtered_heading expected %0d actual %0d",
                             $time, exp_r.heading, m_tdata[23:8]);
                    mismatches++;
                end
            end
        end
    end

    // result side back-pressure
    initial
    begin
        int stall;
        m_tready <= 1'b0;
        @(posedge clk);
        while (!rst_n)
            @(posedge clk);
        forever
        begin
            stall = pick_gap();
            if (stall > 0)
            begin
                m_tready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            m_tready <= 1'b1;
            repeat ($urandom_range(1, 8)) @(posedge clk);
        end
    end

    // watchdog on handshake activity
    always @(posedge clk)
    begin
        if (!rst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("== FAIL ==");
            $finish;
        end
    end

    initial
    begin
        clk            = 1'b0;
        smoothed_hdg   = '0;
        heading_primed = 1'b0;
        weight_cfg     = WEIGHT_RESET;
        gain_cfg       = GAIN_RESET;
        deadzone_cfg   = DEADZONE_RESET;
        mismatches     = 0;
        steady_flow    = 1'b0;
        rst_n    <= 1'b0;
        cfg_we   <= 1'b0;
        cfg_addr <= '0;
        cfg_data <= '0;
        s_tvalid <= 1'b0;
        s_tdata  <= '0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_first_sample();
        test_wrap_and_range();
        test_rudder_limits();
        test_zero_weight();
        test_deadzone_limits();
        test_random_tracking();

        // drain
        s_tvalid <= 1'b0;
        while (pending_steer.size() != 0)
            @(posedge clk);
        repeat (SETTLE) @(posedge clk);
        if (mismatches == 0 && pending_steer.size() == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule

[sim.f]
rtl/hsrc_pkg.sv
rtl/hsrc_ctrl.sv
rtl/hsrc_dp.sv
rtl/heading_smoother_rudder_control_top.sv
tb/heading_smoother_rudder_control_top_test.sv
